// ===== rtl/cbtf_pkg.sv =====
// Package for the caption block timestamp framer.
// Holds sizes, byte constants and codes shared by the framer and its testbench.
package cbtf_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int COUNT_W    = 6;
    localparam int TS_W       = 48;
    localparam int BLK_W      = 24;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    localparam logic [TS_W-1:0] FRAME_MS = TS_W'(33);

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [7:0] PAD_FIELD1  = 8'h04;
    localparam logic [7:0] PAD_FIELD2  = 8'h05;
    localparam logic [1:0] TYPE_DTVCC  = 2'd3;
    localparam logic [1:0] TYPE_NTSC_H = 2'd1;

    localparam logic OP_BLOCK = 1'b0;
    localparam logic OP_END   = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BLOCK  = 1'b1;

endpackage

// ===== rtl/cbtf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbtf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/caption_block_timestamp_framer.sv =====
// Caption block timestamp framer: groups caption blocks by timestamp and emits
// header plus blocks per group. Depends on cbtf_pkg and cbtf_ram.
// Flow: one word at a time; a word with no flush is accepted, then stored.
// A flush first checks the trailing blocks for padding (the kept one included),
// then sends the header and each block in turn (RAM read, output load); end of stream
// adds a padding header and two padding blocks. Output stalls can hold any output word.
// Reset (aresetn low, synchronous): store empty, no previous timestamp, keep_padding 0.
module caption_block_timestamp_framer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic                              cfg_wdata,   // keep_padding
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cbtf_pkg::IN_DATA_W-1:0]    s_tdata,     // timestamp, byte0, byte1, byte2
    input  logic                              s_tuser,     // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cbtf_pkg::OUT_DATA_W-1:0]   m_tdata,     // group_time, group_count,
                                                           // out_byte0..2, 2 zero bits
    output logic                              m_tuser,     // kind
    output logic                              m_tlast      // last
);
    import cbtf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRUNE_RD, ST_PRUNE_CHK, ST_HEAD, ST_BLK_RD, ST_BLK_OUT,
        ST_PAD_HEAD, ST_PAD_B0, ST_PAD_B1, ST_FINISH
    } state_t;

    state_t              state_reg;
    logic                keep_padding_reg;
    logic [TS_W-1:0]     prev_time_reg;
    logic                prev_valid_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic                full_reg;
    logic                end_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [BLK_W-1:0]    blk_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;

    logic                s_accept;
    logic                out_free;
    logic                out_load;
    logic [TS_W-1:0]     in_ts;
    logic [BLK_W-1:0]    in_blk;
    logic                in_full;
    logic                in_flush;
    logic [COUNT_W-1:0]  count_dec;
    logic [TS_W-1:0]     ts_adj;
    logic                blk_storable;
    logic                rd_is_pad;
    logic                idx_is_last;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [BLK_W-1:0]    ram_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free && (((state_reg == ST_HEAD) && (count_reg != '0))
                      || (state_reg inside {ST_BLK_OUT, ST_PAD_HEAD, ST_PAD_B0, ST_PAD_B1}));

    assign in_ts    = s_tdata[TS_W-1:0];
    assign in_blk   = s_tdata[TS_W +: BLK_W];
    assign in_full  = (count_reg >= COUNT_W'(MAX_BLOCKS));
    assign in_flush = (prev_valid_reg && (prev_time_reg != in_ts)) || (s_tuser == OP_END)
                      || in_full;

    assign count_dec = count_reg - COUNT_W'(1);
    assign ts_adj    = ts_reg - FRAME_MS;

    assign blk_storable = blk_reg[2] || (blk_reg[1:0] == TYPE_DTVCC);
    assign rd_is_pad    = ram_rdata[2] && (ram_rdata[1:0] <= TYPE_NTSC_H)
                          && (ram_rdata[15:8] == PAD_BYTE) && (ram_rdata[23:16] == PAD_BYTE);
    assign idx_is_last  = ({{(COUNT_W-ADDR_W){1'b0}}, idx_reg} == count_dec);

    assign ram_we    = (state_reg == ST_FINISH) && (end_reg == OP_BLOCK) && blk_storable
                       && (count_reg < COUNT_W'(MAX_BLOCKS));
    assign ram_raddr = (state_reg == ST_PRUNE_RD) ? count_dec[ADDR_W-1:0] : idx_reg;

    cbtf_ram #(
        .WIDTH(BLK_W),
        .DEPTH(MAX_BLOCKS)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(blk_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            keep_padding_reg <= 1'b0;
            prev_time_reg    <= '1;
            prev_valid_reg   <= 1'b0;
            count_reg        <= '0;
            idx_reg          <= '0;
            full_reg         <= 1'b0;
            end_reg          <= OP_BLOCK;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wen) begin
                keep_padding_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        ts_reg   <= in_ts;
                        blk_reg  <= in_blk;
                        end_reg  <= s_tuser;
                        full_reg <= in_full;
                        if (!in_flush) begin
                            state_reg <= ST_FINISH;
                        end else if (!in_full && !keep_padding_reg && count_reg != '0) begin
                            state_reg <= ST_PRUNE_RD;
                        end else begin
                            state_reg <= ST_HEAD;
                        end
                    end
                end
                ST_PRUNE_RD: begin
                    state_reg <= ST_PRUNE_CHK;
                end
                ST_PRUNE_CHK: begin
                    if (rd_is_pad) begin
                        count_reg <= count_dec;
                        state_reg <= (count_dec == '0) ? ST_HEAD : ST_PRUNE_RD;
                    end else begin
                        state_reg <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if (count_reg == '0) begin
                        state_reg <= (end_reg == OP_END) ? ST_PAD_HEAD : ST_FINISH;
                    end else if (out_free) begin
                        m_tuser_reg  <= KIND_HEADER;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {{(OUT_DATA_W-TS_W-COUNT_W){1'b0}}, count_reg,
                                         prev_time_reg};
                        idx_reg      <= '0;
                        state_reg    <= ST_BLK_RD;
                    end
                end
                ST_BLK_RD: begin
                    state_reg <= ST_BLK_OUT;
                end
                ST_BLK_OUT: begin
                    if (out_free) begin
                        m_tuser_reg  <= KIND_BLOCK;
                        m_tlast_reg  <= idx_is_last && (end_reg == OP_BLOCK);
                        m_tdata_reg  <= {{(OUT_DATA_W-BLK_W-TS_W-COUNT_W){1'b0}}, ram_rdata,
                                         {(TS_W+COUNT_W){1'b0}}};
                        if (idx_is_last) begin
                            count_reg <= '0;
                            state_reg <= (end_reg == OP_END) ? ST_PAD_HEAD : ST_FINISH;
                        end else begin
                            idx_reg   <= idx_reg + ADDR_W'(1);
                            state_reg <= ST_BLK_RD;
                        end
                    end
                end
                ST_PAD_HEAD: begin
                    if (out_free) begin
                        m_tuser_reg  <= KIND_HEADER;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {{(OUT_DATA_W-TS_W-COUNT_W){1'b0}}, COUNT_W'(2),
                                         ts_adj};
                        state_reg    <= ST_PAD_B0;
                    end
                end
                ST_PAD_B0: begin
                    if (out_free) begin
                        m_tuser_reg  <= KIND_BLOCK;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {{(OUT_DATA_W-BLK_W-TS_W-COUNT_W){1'b0}}, PAD_BYTE,
                                         PAD_BYTE, PAD_FIELD1, {(TS_W+COUNT_W){1'b0}}};
                        state_reg    <= ST_PAD_B1;
                    end
                end
                ST_PAD_B1: begin
                    if (out_free) begin
                        m_tuser_reg  <= KIND_BLOCK;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {{(OUT_DATA_W-BLK_W-TS_W-COUNT_W){1'b0}}, PAD_BYTE,
                                         PAD_BYTE, PAD_FIELD2, {(TS_W+COUNT_W){1'b0}}};
                        state_reg    <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    prev_valid_reg <= 1'b1;
                    if (end_reg == OP_END) begin
                        prev_time_reg <= ts_adj;
                        count_reg     <= '0;
                    end else begin
                        prev_time_reg <= ts_reg;
                        if (ram_we) begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_BLOCKS))
        else $error("store count above capacity");

    a_header_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == KIND_HEADER)) |-> (m_tdata_reg[TS_W +: COUNT_W] != '0))
        else $error("header with zero count");

    a_header_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == KIND_HEADER)) |-> !m_tlast_reg)
        else $error("header marked last");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("ready right after accept");

    a_prune_only_dropping: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRUNE_CHK) |-> (!full_reg && !keep_padding_reg))
        else $error("pruning on full store or with keep_padding");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for caption_block_timestamp_framer: directed, full-store, stall and random tests.
// Predicts header and block words per input word and checks every output word in order.
// Depends on cbtf_pkg and the framer RTL only.
module tb;
    import cbtf_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 200;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        bit            kind;
        bit [TS_W-1:0] gtime;
        bit [5:0]      gcount;
        bit [7:0]      ob0;
        bit [7:0]      ob1;
        bit [7:0]      ob2;
        bit            is_last;
    } out_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wen;
    logic                  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    caption_block_timestamp_framer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // framer model state
    bit            keep_pad_model;
    bit [TS_W-1:0] last_time;
    bit            time_seen;
    bit [BLK_W-1:0] held[MAX_BLOCKS];
    int            held_count;

    out_word_t expected_words[$];

    int  mismatch_count;
    int  words_sent;
    int  ends_sent;
    int  words_checked;
    int  headers_seen;
    bit  tx_no_idle;
    bit  rx_no_idle;
    int  rx_hold_req = 0;
    int  rx_hold_left;
    int  rx_gap;
    bit  [TS_W-1:0] stream_time;

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic bit is_storable(bit [7:0] b0);
        return b0[2] || b0[1:0] == TYPE_DTVCC;
    endfunction

    function automatic void queue_result(bit kind, bit [TS_W-1:0] t, bit [5:0] cnt,
                                         bit [7:0] b0, bit [7:0] b1, bit [7:0] b2);
        out_word_t w;
        w.kind    = kind;
        w.gtime   = t;
        w.gcount  = cnt;
        w.ob0     = b0;
        w.ob1     = b1;
        w.ob2     = b2;
        w.is_last = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void emit_group(bit full);
        bit [BLK_W-1:0] w;
        bit             done;
        done = 1'b0;
        if (!full) begin
            // drop trailing padding
            while (held_count > 0 && !done) begin
                w = held[held_count-1];
                if ((w[2] && w[1:0] <= TYPE_NTSC_H && !keep_pad_model &&
                     w[15:8] == PAD_BYTE && w[23:16] == PAD_BYTE) || !is_storable(w[7:0]))
                    held_count--;
                else
                    done = 1'b1;
            end
        end
        if (held_count > 0) begin
            queue_result(KIND_HEADER, last_time, 6'(held_count), '0, '0, '0);
            for (int i = 0; i < held_count; i++)
                queue_result(KIND_BLOCK, '0, '0, held[i][7:0], held[i][15:8], held[i][23:16]);
        end
        held_count = 0;
    endfunction

    function automatic void frame_word(bit op, bit [TS_W-1:0] ts,
                                       bit [7:0] b0, bit [7:0] b1, bit [7:0] b2);
        bit            full;
        bit [TS_W-1:0] now;
        int            start_size;
        out_word_t     w;
        start_size = expected_words.size();
        now = ts;
        full = held_count >= MAX_BLOCKS;
        if ((time_seen && last_time != now) || op == OP_END || full)
            emit_group(full);
        if (op == OP_BLOCK) begin
            if (is_storable(b0) && held_count < MAX_BLOCKS) begin
                held[held_count] = {b2, b1, b0};
                held_count++;
            end
        end else begin
            now = now - FRAME_MS;
            queue_result(KIND_HEADER, now, 6'd2, '0, '0, '0);
            queue_result(KIND_BLOCK, '0, '0, PAD_FIELD1, PAD_BYTE, PAD_BYTE);
            queue_result(KIND_BLOCK, '0, '0, PAD_FIELD2, PAD_BYTE, PAD_BYTE);
            held_count = 0;
        end
        last_time = now;
        time_seen = 1'b1;
        if (expected_words.size() > start_size) begin
            w = expected_words.pop_back();
            w.is_last = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH word %0d: %s got %0h want %0h", words_checked, what, got, want);
    endtask

    // output checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[47:0], 0);
            end else begin
                want = expected_words.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[47:0] != want.gtime)
                    report_mismatch("group_time", m_tdata[47:0], want.gtime);
                if (m_tdata[53:48] != want.gcount)
                    report_mismatch("group_count", m_tdata[53:48], want.gcount);
                if (m_tdata[61:54] != want.ob0)
                    report_mismatch("out_byte0", m_tdata[61:54], want.ob0);
                if (m_tdata[69:62] != want.ob1)
                    report_mismatch("out_byte1", m_tdata[69:62], want.ob1);
                if (m_tdata[77:70] != want.ob2)
                    report_mismatch("out_byte2", m_tdata[77:70], want.ob2);
                if (m_tdata[79:78] != 2'b00)
                    report_mismatch("spare bits", m_tdata[79:78], 0);
                if (m_tlast != want.is_last)
                    report_mismatch("last", m_tlast, want.is_last);
                if (want.kind == KIND_HEADER)
                    headers_seen++;
            end
            words_checked++;
        end
    end

    // output ready: random gaps, or a long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
            rx_hold_left = 0;
        end else if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req <= 0;
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!rx_no_idle && $urandom_range(0, 3) == 0)
                rx_gap = pick_gap();
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("no handshake for %0d cycles, %0d words still pending",
                 STALL_LIMIT, expected_words.size());
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_word(bit op, bit [TS_W-1:0] ts, bit [7:0] b0, bit [7:0] b1,
                             bit [7:0] b2);
        int gap;
        gap = 0;
        if (!tx_no_idle && $urandom_range(0, 1) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b2, b1, b0, ts};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_word(op, ts, b0, b1, b2);
        words_sent++;
        if (op == OP_END)
            ends_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_keep_padding(bit value);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        keep_pad_model = value;
    endtask

    function automatic bit [7:0] storable_byte0();
        bit [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            b[1:0] = TYPE_DTVCC;
        else
            b[2] = 1'b1;
        return b;
    endfunction

    function automatic bit [7:0] pad_byte0();
        bit [7:0] b;
        b = 8'($urandom);
        b[2] = 1'b1;
        b[1:0] = 2'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic send_pad(bit [TS_W-1:0] ts);
        send_word(OP_BLOCK, ts, pad_byte0(), PAD_BYTE, PAD_BYTE);
    endtask

    task automatic test_directed_cases();
        // first word at time -1 must not flush
        send_word(OP_BLOCK, '1, 8'h04, 8'h11, 8'h22);
        send_word(OP_BLOCK, '1, 8'h03, 8'hAA, 8'h55);
        send_word(OP_BLOCK, '1, 8'h00, 8'hFF, 8'hFF);
        send_word(OP_BLOCK, '1, 8'h06, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, '1, PAD_FIELD1, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, '1, PAD_FIELD2, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, '0, 8'hFF, 8'h00, 8'h00);
        send_word(OP_BLOCK, '0, 8'hF8, 8'hFF, 8'hFF);
        send_word(OP_BLOCK, 48'h7FFF_FFFF_FFFF, 8'h07, 8'h01, 8'h02);
        send_word(OP_BLOCK, 48'h8000_0000_0000, 8'h02, 8'h80, 8'h01);
        send_word(OP_BLOCK, 48'h8000_0000_0000, 8'h01, PAD_BYTE, PAD_BYTE);
        send_word(OP_END, 48'h8000_0000_0000, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_END, '0, 8'h00, 8'h00, 8'h00);
        // group of padding only vanishes
        send_word(OP_BLOCK, 48'd5, PAD_FIELD1, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, 48'd5, PAD_FIELD2, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, 48'd38, 8'h0D, 8'h80, 8'h7F);
        send_word(OP_BLOCK, 48'd38, 8'h0C, PAD_BYTE, PAD_BYTE);
        send_word(OP_END, 48'd38, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic test_keep_padding();
        write_keep_padding(1'b1);
        send_word(OP_BLOCK, 48'd100, 8'h04, 8'h41, 8'h42);
        send_word(OP_BLOCK, 48'd100, PAD_FIELD1, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, 48'd100, PAD_FIELD2, PAD_BYTE, PAD_BYTE);
        send_word(OP_BLOCK, 48'd133, 8'h05, PAD_BYTE, PAD_BYTE);
        send_word(OP_END, 48'd166, 8'h00, 8'h00, 8'h00);
        write_keep_padding(1'b0);
    endtask

    task automatic test_full_store();
        bit [TS_W-1:0] t;
        t = 48'd1000;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (i >= MAX_BLOCKS - 2)
                send_pad(t);
            else
                send_word(OP_BLOCK, t, storable_byte0(), 8'($urandom), 8'($urandom));
        end
        // store full: same time still flushes everything, padding kept
        send_word(OP_BLOCK, t, storable_byte0(), 8'($urandom), 8'($urandom));
        for (int i = 1; i < MAX_BLOCKS; i++) begin
            if (i == MAX_BLOCKS - 1)
                send_pad(t);
            else
                send_word(OP_BLOCK, t, storable_byte0(), 8'($urandom), 8'($urandom));
        end
        // full and time change together
        send_word(OP_BLOCK, t + FRAME_MS, storable_byte0(), PAD_BYTE, PAD_BYTE);
        send_word(OP_END, t + FRAME_MS, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic send_random_group();
        int       n;
        int       pads;
        int       sel;
        bit [7:0] b0;
        bit [7:0] b1;
        bit [7:0] b2;
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
            send_word($urandom_range(0, 7) == 0 ? OP_END : OP_BLOCK,
                      TS_W'({$urandom, $urandom}), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 4) begin
            send_word(OP_END, stream_time, 8'($urandom), 8'($urandom), 8'($urandom));
            stream_time = stream_time + FRAME_MS;
        end else begin
            if ($urandom_range(0, 7) != 0)
                stream_time = stream_time + FRAME_MS + TS_W'($urandom_range(0, 1));
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 5);
            pads = $urandom_range(0, 2);
            for (int i = 0; i < n + pads; i++) begin
                b1 = 8'($urandom);
                b2 = 8'($urandom);
                sel = $urandom_range(0, 9);
                if (i >= n || sel == 1) begin
                    b0 = pad_byte0();
                    b1 = PAD_BYTE;
                    b2 = PAD_BYTE;
                end else if (sel == 0) begin
                    b0 = 8'($urandom);
                    b0[2] = 1'b0;
                    b0[1:0] = 2'($urandom_range(0, 2));
                end else if (sel == 2) begin
                    b0 = 8'($urandom);
                end else begin
                    b0 = storable_byte0();
                    if ($urandom_range(0, 3) == 0)
                        b1 = PAD_BYTE;
                    if ($urandom_range(0, 3) == 0)
                        b2 = PAD_BYTE;
                end
                send_word(OP_BLOCK, stream_time, b0, b1, b2);
            end
        end
    endtask

    task automatic test_output_stall();
        int target;
        target = words_sent + 40;
        stream_time = 48'd5000;
        rx_hold_req <= 600;
        while (words_sent < target) begin
            stream_time = stream_time + FRAME_MS;
            send_word(OP_BLOCK, stream_time, storable_byte0(), 8'($urandom), 8'($urandom));
            send_word(OP_BLOCK, stream_time, storable_byte0(), 8'($urandom), 8'($urandom));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(bit keep_pad, int count, bit busy);
        int target;
        write_keep_padding(keep_pad);
        tx_no_idle = busy;
        rx_no_idle = busy;
        stream_time = TS_W'({$urandom, $urandom});
        target = words_sent + count;
        while (words_sent < target)
            send_random_group();
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        keep_pad_model = 1'b0;
        last_time      = '1;
        time_seen      = 1'b0;
        held_count     = 0;
        mismatch_count = 0;
        words_sent     = 0;
        ends_sent      = 0;
        words_checked  = 0;
        headers_seen   = 0;
        tx_no_idle     = 1'b0;
        rx_no_idle     = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_keep_padding();
        test_full_store();
        test_output_stall();
        test_random_traffic(1'b0, 36, 1'b0);
        test_random_traffic(1'b1, 36, 1'b0);
        test_random_traffic(1'b0, 36, 1'b1);
        test_random_traffic(1'b1, 36, 1'b0);

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d words (%0d end of stream), checked %0d output words in %0d groups",
                 words_sent, ends_sent, words_checked, headers_seen);
        $display("padding kept and pruned, full store flushes, long output stall, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
